FILE: rtl/core/form_query_splitter_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the form query splitter/decoder core
// Shared wrappers for concurrent checks, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef FORM_QUERY_SPLITTER_DECODER_CORE_DEFINES_SVH
`define FORM_QUERY_SPLITTER_DECODER_CORE_DEFINES_SVH

// Same-cycle implication
`define FQSD_ASSERT_NOW(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication
`define FQSD_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/core/fqsd_pkg.sv
// ----------------------------------------------------------------------------
// fqsd_pkg
// Types, character codes and phase codes for the query splitter/decoder.
// ----------------------------------------------------------------------------
package fqsd_pkg;

	// characters of interest
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// split phases
	localparam logic [2:0] PH_NAME   = 3'd0;
	localparam logic [2:0] PH_VSTART = 3'd1;
	localparam logic [2:0] PH_PLAIN  = 3'd2;
	localparam logic [2:0] PH_QUOTED = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;

	// escape phases
	localparam logic [1:0] ESC_TEXT  = 2'd0;
	localparam logic [1:0] ESC_PCT   = 2'd1;
	localparam logic [1:0] ESC_DIGIT = 2'd2;

	// most result words one input word can cause
	localparam int MAX_RES = 4;
	localparam int NRES_W  = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       in_value;
		logic       field_end;
		logic       name_dropped;
		logic       run_last;
	} result_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
		end
		return d[3:0];
	endfunction

	function automatic result_t mk_res(input logic [7:0] b, input logic has,
		input logic val, input logic fend, input logic drop);
		result_t r;
		r.out_byte     = b;
		r.has_byte     = has;
		r.in_value     = val;
		r.field_end    = fend;
		r.name_dropped = drop;
		r.run_last     = 1'b0;
		return r;
	endfunction

endpackage

FILE: rtl/core/fqsd_in_if.sv
// ----------------------------------------------------------------------------
// fqsd_in_if
// Input channel: one query string character per word.
// ----------------------------------------------------------------------------
interface fqsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/core/fqsd_out_if.sv
// ----------------------------------------------------------------------------
// fqsd_out_if
// Output channel: one decoded byte or field marker per word.
// ----------------------------------------------------------------------------
interface fqsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       in_value;
	logic       field_end;
	logic       name_dropped;
	logic       run_last;

	modport source (output valid, output out_byte, output has_byte, output in_value,
		output field_end, output name_dropped, output run_last, input ready);
	modport sink   (input valid, input out_byte, input has_byte, input in_value,
		input field_end, input name_dropped, input run_last, output ready);
endinterface

FILE: rtl/core/form_query_splitter_decoder_core.sv
// ----------------------------------------------------------------------------
// form_query_splitter_decoder_core
// Splits a form-encoded query string into name/value fields and decodes
// '+' and percent escapes on the fly, one character in per cycle while the queue has room.
//
//   channel   dir   word
//   in_ch     in    in_byte[7:0], in_last
//   out_ch    out   out_byte[7:0], has_byte, in_value, field_end,
//                   name_dropped, run_last
//
// An accepted character is held in the input register; the split/decode
// logic works out its 0..4 result words from it and writes them into a
// QDEPTH-entry queue once they fit, and the queue head drives out_ch.
// One character per cycle is taken while the queue has room for that
// character's results; the queue drains one word per cycle while out_ch is ready.
// arst_n clears the phases, the held digit and the queue pointers.
// A stalled output only stops input once the queue lacks room.
// ----------------------------------------------------------------------------
`include "form_query_splitter_decoder_core_defines.svh"

module form_query_splitter_decoder_core #(
	parameter int QDEPTH = 8	// queue depth, a power of two, at least 4
) (
	input logic       clk,
	input logic       arst_n,
	fqsd_in_if.sink   in_ch,
	fqsd_out_if.source out_ch
);
	import fqsd_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// split/decode state
	logic [2:0] phase_q;
	logic [1:0] esc_q;
	logic [7:0] held_q;
	logic       seen_q;

	// result queue
	result_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;

	// combinational results of the stage
	result_t             res [MAX_RES];
	logic [NRES_W-1:0]   nres;
	logic [2:0]          phase_n;
	logic [1:0]          esc_n;
	logic [7:0]          held_n;
	logic                seen_n;
	logic                go;
	logic                pop;

	// split, decode and end-of-string handling
	always_comb begin
		logic       do_dec;
		logic       do_close;
		logic       fval;
		logic [7:0] c;
		c        = byte_s1;
		do_dec   = 1'b0;
		do_close = 1'b0;
		fval     = 1'b0;
		phase_n  = phase_q;
		esc_n    = esc_q;
		held_n   = held_q;
		seen_n   = seen_q;
		nres     = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '0;
		end

		// field splitting
		case (phase_q)
			PH_VSTART: begin
				fval = 1'b1;
				if (c == CH_QUOTE) begin
					phase_n = PH_QUOTED;
				end else if (c == CH_AMP) begin
					do_close = 1'b1;
					phase_n  = PH_NAME;
				end else begin
					do_dec  = 1'b1;
					phase_n = PH_PLAIN;
				end
			end
			PH_PLAIN: begin
				fval = 1'b1;
				if (c == CH_AMP) begin
					do_close = 1'b1;
					phase_n  = PH_NAME;
				end else begin
					do_dec = 1'b1;
				end
			end
			PH_QUOTED: begin
				fval = 1'b1;
				if (c == CH_QUOTE) begin
					do_close = 1'b1;
					phase_n  = PH_SKIP;
				end else begin
					do_dec = 1'b1;
				end
			end
			PH_SKIP: begin
				if (c == CH_AMP) begin
					phase_n = PH_NAME;
				end
			end
			default: begin
				// name phase, also unused codes
				if (c == CH_EQ) begin
					do_close = 1'b1;
					seen_n   = 1'b0;
					phase_n  = PH_VSTART;
				end else begin
					do_dec  = 1'b1;
					seen_n  = 1'b1;
					phase_n = PH_NAME;
				end
			end
		endcase

		// escape decoding
		if (do_dec) begin
			case (esc_q)
				ESC_PCT: begin
					if (c == CH_PCT) begin
						res[nres[1:0]] = mk_res(CH_PCT, 1'b1, fval, 1'b0, 1'b0);
						nres = nres + 3'd1;
						esc_n = ESC_TEXT;
					end else if (is_hex(c)) begin
						held_n = c;
						esc_n  = ESC_DIGIT;
					end else begin
						res[nres[1:0]] = mk_res(CH_PCT, 1'b1, fval, 1'b0, 1'b0);
						nres = nres + 3'd1;
						res[nres[1:0]] = mk_res(c, 1'b1, fval, 1'b0, 1'b0);
						nres = nres + 3'd1;
						esc_n = ESC_TEXT;
					end
				end
				ESC_DIGIT: begin
					if (is_hex(c)) begin
						res[nres[1:0]] = mk_res({hex_val(held_q), hex_val(c)}, 1'b1, fval,
							1'b0, 1'b0);
						nres = nres + 3'd1;
					end else begin
						// bad second digit: put the escape back as is
						res[nres[1:0]] = mk_res(CH_PCT, 1'b1, fval, 1'b0, 1'b0);
						nres = nres + 3'd1;
						res[nres[1:0]] = mk_res(held_q, 1'b1, fval, 1'b0, 1'b0);
						nres = nres + 3'd1;
						res[nres[1:0]] = mk_res(c, 1'b1, fval, 1'b0, 1'b0);
						nres = nres + 3'd1;
					end
					esc_n  = ESC_TEXT;
					held_n = 8'h00;
				end
				default: begin
					if (c == CH_PCT) begin
						esc_n = ESC_PCT;
					end else begin
						res[nres[1:0]] = mk_res((c == CH_PLUS) ? CH_SPACE : c, 1'b1, fval,
							1'b0, 1'b0);
						nres = nres + 3'd1;
					end
				end
			endcase
		end

		// field close drops any unfinished escape
		if (do_close) begin
			res[nres[1:0]] = mk_res(8'h00, 1'b0, fval, 1'b1, 1'b0);
			nres   = nres + 3'd1;
			esc_n  = ESC_TEXT;
			held_n = 8'h00;
		end

		// end of string: close open value or drop a pending name, then reset
		if (last_s1) begin
			if (phase_n == PH_VSTART || phase_n == PH_PLAIN || phase_n == PH_QUOTED) begin
				res[nres[1:0]] = mk_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
				nres = nres + 3'd1;
			end else if (phase_n != PH_SKIP && seen_n) begin
				res[nres[1:0]] = mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
				nres = nres + 3'd1;
			end
			phase_n = PH_NAME;
			esc_n   = ESC_TEXT;
			held_n  = 8'h00;
			seen_n  = 1'b0;
		end

		// run_last marks the final word of the character
		for (int i = 0; i < MAX_RES; i++) begin
			res[i].run_last = (NRES_W'(i) == nres - 3'd1);
		end
	end

	// stage advances when the queue has room for all its results
	assign go  = valid_s1 &&
		(({1'b0, cnt_q} + (CNT_W + 1)'(nres)) <= (CNT_W + 1)'(QDEPTH));
	assign pop = out_ch.valid && out_ch.ready;

	assign in_ch.ready = !valid_s1 || go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	// split/decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAME;
			esc_q   <= ESC_TEXT;
			held_q  <= 8'h00;
			seen_q  <= 1'b0;
		end else if (go) begin
			phase_q <= phase_n;
			esc_q   <= esc_n;
			held_q  <= held_n;
			seen_q  <= seen_n;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (NRES_W'(i) < nres) begin
					mem_q[wr_ptr_q + PTR_W'(i)] <= res[i];
				end
			end
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (go) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(nres);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (go ? CNT_W'(nres) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	// output from queue head
	assign out_ch.valid        = (cnt_q != '0);
	assign out_ch.out_byte     = mem_q[rd_ptr_q].out_byte;
	assign out_ch.has_byte     = mem_q[rd_ptr_q].has_byte;
	assign out_ch.in_value     = mem_q[rd_ptr_q].in_value;
	assign out_ch.field_end    = mem_q[rd_ptr_q].field_end;
	assign out_ch.name_dropped = mem_q[rd_ptr_q].name_dropped;
	assign out_ch.run_last     = mem_q[rd_ptr_q].run_last;

	// checks
	`FQSD_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(QDEPTH))
	`FQSD_ASSERT_NEXT(a_last_resets, clk, arst_n, go && last_s1, phase_q == PH_NAME && esc_q == ESC_TEXT && !seen_q && held_q == 8'h00)
	`FQSD_ASSERT_NEXT(a_cnt_step, clk, arst_n, go && !pop, cnt_q == $past(cnt_q) + CNT_W'($past(nres)))

endmodule
